>>> design/ccsc_pkg.sv
// ----------------------------------------------------------------------------
// ccsc_pkg
// shared constants, register codes and the record type passed front to back
// ----------------------------------------------------------------------------
`default_nettype none

package ccsc_pkg;

    // defaults for the top level parameters
    localparam int MAX_GEN_BITS_DEF = 17;
    localparam int COUNT_BITS_DEF   = 32;

    // record queue depth between the bit engine and the beat emitter
    localparam int QUEUE_DEPTH = 4;

    // configuration register codes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_GEN_POLY   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GEN_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_MODE  = 2'd2;

    // register widths and reset values
    localparam int GEN_LENGTH_W       = 5;
    localparam int GEN_POLY_RESET     = 11;
    localparam int GEN_LENGTH_RESET   = 4;
    localparam logic DATA_MODE_RESET  = 1'b0;

    // dataword sizes
    localparam int DATA_BITS_SHORT = 4;
    localparam int DATA_BITS_LONG  = 8;

    // result field widths
    localparam int TOTAL_W = 32;

    // result kinds
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // beat slots of one record, in output order
    localparam int BEAT_DATA    = 0;
    localparam int BEAT_FLUSH   = 1;
    localparam int BEAT_SUMMARY = 2;
    localparam int BEAT_SLOTS   = 3;

    // everything one input byte leaves for the output side
    typedef struct packed {
        logic               has_data;
        logic [7:0]         data_byte;
        logic               has_flush;
        logic [7:0]         flush_byte;
        logic               eos;
        logic [TOTAL_W-1:0] frame_total;
        logic [TOTAL_W-1:0] error_total;
    } rec_t;

endpackage

`default_nettype wire

>>> design/ccsc_front.sv
// ----------------------------------------------------------------------------
// ccsc_front
// configuration registers, pad skip, unrolled crc bit engine and data packing
// ----------------------------------------------------------------------------
`default_nettype none

module ccsc_front #(
    parameter int MAX_GEN_BITS = ccsc_pkg::MAX_GEN_BITS_DEF,
    parameter int COUNT_BITS   = ccsc_pkg::COUNT_BITS_DEF,
    localparam int CFG_W = (MAX_GEN_BITS > ccsc_pkg::GEN_LENGTH_W) ?
                           MAX_GEN_BITS : ccsc_pkg::GEN_LENGTH_W
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ccsc_pkg::CFG_INDEX_W-1:0]    cfg_wr_index,
    input  wire logic [CFG_W-1:0]                    cfg_wr_data,
    input  wire logic                                in_accept,
    input  wire logic [7:0]                          in_byte,
    input  wire logic                                in_last,
    output ccsc_pkg::rec_t                           rec,
    output logic                                     rec_push
);

    localparam int RW = MAX_GEN_BITS - 1;                 // remainder width
    localparam int LW = $clog2(MAX_GEN_BITS + 1);         // generator length
    localparam int IW = $clog2(MAX_GEN_BITS + 8);         // codeword bit index

    // configuration
    logic [RW-1:0]                     gen_poly_reg;
    logic [ccsc_pkg::GEN_LENGTH_W-1:0] gen_length_reg;
    logic                              data_mode_reg;

    // stream state
    logic                  header_seen_reg, header_seen_next;
    logic [7:0]            pad_reg, pad_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic [7:0]            hold_reg, hold_next;
    logic                  half_reg, half_next;
    logic [3:0]            nib_reg, nib_next;
    logic [COUNT_BITS-1:0] frames_reg, frames_next;
    logic [COUNT_BITS-1:0] errors_reg, errors_next;

    logic [LW-1:0] eff_len;
    logic [LW-1:0] rem_bits;
    logic [RW-1:0] rmask;
    logic [RW-1:0] topmask;
    logic [RW-1:0] poly_m;
    logic [IW-1:0] dw;
    logic [IW-1:0] cw_len;

    logic [1:0]          fr_inc, er_inc;
    logic                emit;
    logic [7:0]          emit_byte;
    logic [COUNT_BITS:0] fr_sum, er_sum;

    // clamp the generator length and derive masks
    always_comb begin
        if (gen_length_reg < ccsc_pkg::GEN_LENGTH_W'(2)) begin
            eff_len = LW'(2);
        end else if (int'(gen_length_reg) > MAX_GEN_BITS) begin
            eff_len = LW'(MAX_GEN_BITS);
        end else begin
            eff_len = LW'(gen_length_reg);
        end
        rem_bits = eff_len - LW'(1);
        rmask    = {RW{1'b1}} >> (LW'(RW) - rem_bits);
        topmask  = RW'(1) << (rem_bits - LW'(1));
        poly_m   = gen_poly_reg & rmask;
        dw       = data_mode_reg ? IW'(ccsc_pkg::DATA_BITS_LONG)
                                 : IW'(ccsc_pkg::DATA_BITS_SHORT);
        cw_len   = dw + IW'(rem_bits);
    end

    // eight bit steps of one byte, msb first
    always_comb begin
        logic [7:0]    pad;
        logic [IW-1:0] idx;
        logic [RW-1:0] rem;
        logic [7:0]    hold;
        logic          half;
        logic [3:0]    nib;
        logic          top;
        logic          b;

        pad       = pad_reg;
        idx       = idx_reg;
        rem       = rem_reg;
        hold      = hold_reg;
        half      = half_reg;
        nib       = nib_reg;
        fr_inc    = 2'd0;
        er_inc    = 2'd0;
        emit      = 1'b0;
        emit_byte = 8'd0;
        top       = 1'b0;
        b         = 1'b0;

        if (header_seen_reg) begin
            for (int i = 7; i >= 0; i--) begin
                if (pad != 8'd0) begin
                    pad = pad - 8'd1;
                end else begin
                    b = in_byte[i];
                    if (idx < dw) begin
                        hold = {hold[6:0], b};
                    end
                    rem = rem & rmask;
                    top = |(rem & topmask);
                    rem = ((rem << 1) | RW'(b)) & rmask;
                    if (top) begin
                        rem = rem ^ poly_m;
                    end
                    idx = idx + IW'(1);
                    if (idx >= cw_len) begin
                        fr_inc = fr_inc + 2'd1;
                        if (rem != '0) begin
                            er_inc = er_inc + 2'd1;
                        end
                        // packer holds either nothing or one nibble
                        if (data_mode_reg) begin
                            emit = 1'b1;
                            if (half) begin
                                emit_byte = {nib, hold[7:4]};
                                nib       = hold[3:0];
                            end else begin
                                emit_byte = hold;
                            end
                        end else begin
                            if (half) begin
                                emit      = 1'b1;
                                emit_byte = {nib, hold[3:0]};
                                half      = 1'b0;
                            end else begin
                                nib  = hold[3:0];
                                half = 1'b1;
                            end
                        end
                        idx  = '0;
                        rem  = '0;
                        hold = 8'd0;
                    end
                end
            end
        end

        pad_next  = header_seen_reg ? pad : in_byte;
        idx_next  = idx;
        rem_next  = rem;
        hold_next = hold;
        half_next = half;
        nib_next  = nib;
    end

    // saturating counters, up to two codewords per byte
    always_comb begin
        fr_sum      = {1'b0, frames_reg} + (COUNT_BITS + 1)'(fr_inc);
        er_sum      = {1'b0, errors_reg} + (COUNT_BITS + 1)'(er_inc);
        frames_next = fr_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : fr_sum[COUNT_BITS-1:0];
        errors_next = er_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : er_sum[COUNT_BITS-1:0];
        header_seen_next = 1'b1;
    end

    // record for the output side
    always_comb begin
        rec.has_data    = emit;
        rec.data_byte   = emit_byte;
        rec.has_flush   = in_last && half_next;
        rec.flush_byte  = {nib_next, 4'd0};
        rec.eos         = in_last;
        rec.frame_total = ccsc_pkg::TOTAL_W'(frames_next);
        rec.error_total = ccsc_pkg::TOTAL_W'(errors_next);
        rec_push        = in_accept && (emit || (in_last && half_next) || in_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_poly_reg   <= RW'(ccsc_pkg::GEN_POLY_RESET);
            gen_length_reg <= ccsc_pkg::GEN_LENGTH_W'(ccsc_pkg::GEN_LENGTH_RESET);
            data_mode_reg  <= ccsc_pkg::DATA_MODE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                ccsc_pkg::REG_GEN_POLY: begin
                    gen_poly_reg <= cfg_wr_data[RW-1:0];
                end
                ccsc_pkg::REG_GEN_LENGTH: begin
                    gen_length_reg <= cfg_wr_data[ccsc_pkg::GEN_LENGTH_W-1:0];
                end
                ccsc_pkg::REG_DATA_MODE: begin
                    data_mode_reg <= cfg_wr_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_accept && in_last)) begin
            header_seen_reg <= 1'b0;
            pad_reg         <= 8'd0;
            idx_reg         <= '0;
            rem_reg         <= '0;
            hold_reg        <= 8'd0;
            half_reg        <= 1'b0;
            nib_reg         <= 4'd0;
            frames_reg      <= '0;
            errors_reg      <= '0;
        end else if (in_accept) begin
            header_seen_reg <= header_seen_next;
            pad_reg         <= pad_next;
            idx_reg         <= idx_next;
            rem_reg         <= rem_next;
            hold_reg        <= hold_next;
            half_reg        <= half_next;
            nib_reg         <= nib_next;
            frames_reg      <= frames_next;
            errors_reg      <= errors_next;
        end
    end

    // end of stream leaves a fresh stream behind
    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_last) |=>
            (!header_seen_reg && !half_reg && frames_reg == '0 && errors_reg == '0))
        else $error("stream state not cleared after end of stream");

endmodule

`default_nettype wire

>>> design/ccsc_queue.sv
// ----------------------------------------------------------------------------
// ccsc_queue
// short record fifo between the bit engine and the beat emitter
// ----------------------------------------------------------------------------
`default_nettype none

module ccsc_queue #(
    parameter int DEPTH = ccsc_pkg::QUEUE_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire ccsc_pkg::rec_t wr_rec,
    output logic                ready,
    input  wire logic           pop,
    output ccsc_pkg::rec_t      rd_rec,
    output logic                empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ccsc_pkg::rec_t entries [DEPTH];

    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign ready  = count_reg < CW'(DEPTH);
    assign empty  = count_reg == '0;
    assign rd_rec = entries[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CW'(1);
                2'b01:   count_reg <= count_reg - CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < CW'(DEPTH)))
        else $error("record pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("record popped from an empty queue");

endmodule

`default_nettype wire

>>> design/ccsc_back.sv
// ----------------------------------------------------------------------------
// ccsc_back
// beat emitter: turns each record into data, flush and summary beats
// ----------------------------------------------------------------------------
`default_nettype none

module ccsc_back (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire ccsc_pkg::rec_t                   head,
    input  wire logic                             empty,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [2*ccsc_pkg::TOTAL_W+7:0]        m_tdata,
    output logic                                  m_tuser,
    output logic                                  m_tlast
);

    ccsc_pkg::rec_t cur_reg;
    logic [ccsc_pkg::BEAT_SLOTS-1:0] mask_reg, mask_next;

    logic                            m_valid_reg;
    logic [7:0]                      m_byte_reg;
    logic [ccsc_pkg::TOTAL_W-1:0]    m_ft_reg, m_et_reg;
    logic                            m_kind_reg;
    logic                            m_last_reg;

    ccsc_pkg::rec_t                  src;
    logic [ccsc_pkg::BEAT_SLOTS-1:0] src_mask;
    logic                            use_cur;
    logic                            out_free;
    logic                            load;
    logic [7:0]                      beat_byte;
    logic                            beat_kind;

    always_comb begin
        out_free = !m_valid_reg || m_tready;
        use_cur  = mask_reg != '0;
        src      = use_cur ? cur_reg : head;
        src_mask = '0;
        if (use_cur) begin
            src_mask = mask_reg;
        end else begin
            src_mask[ccsc_pkg::BEAT_DATA]    = head.has_data;
            src_mask[ccsc_pkg::BEAT_FLUSH]   = head.has_flush;
            src_mask[ccsc_pkg::BEAT_SUMMARY] = head.eos;
        end
        load = out_free && (use_cur || !empty);
        pop  = load && !use_cur;

        // lowest pending slot goes out first
        if (src_mask[ccsc_pkg::BEAT_DATA]) begin
            beat_byte = src.data_byte;
            beat_kind = ccsc_pkg::KIND_DATA;
        end else if (src_mask[ccsc_pkg::BEAT_FLUSH]) begin
            beat_byte = src.flush_byte;
            beat_kind = ccsc_pkg::KIND_DATA;
        end else begin
            beat_byte = 8'd0;
            beat_kind = ccsc_pkg::KIND_SUMMARY;
        end
        mask_next = src_mask & (src_mask - ccsc_pkg::BEAT_SLOTS'(1));
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head;
        end
        if (load) begin
            m_byte_reg <= beat_byte;
            m_ft_reg   <= src.frame_total;
            m_et_reg   <= src.error_total;
            m_kind_reg <= beat_kind;
            m_last_reg <= beat_kind == ccsc_pkg::KIND_SUMMARY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else if (load) begin
            mask_reg    <= mask_next;
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_et_reg, m_ft_reg, m_byte_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    a_keeps_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_free && (mask_reg != '0 || !empty)) |=> m_valid_reg)
        else $error("output register left empty with beats pending");

    a_pop_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (mask_reg == '0))
        else $error("record popped before the current one was drained");

endmodule

`default_nettype wire

>>> design/crc_codeword_stream_checker.sv
// ----------------------------------------------------------------------------
// crc_codeword_stream_checker
// checks crc codewords in a byte stream, strips the check bits and reports
// the frame and error counts at the end of each stream
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata[7:0] stream byte, s_tlast end of stream
//  m_       out  m_tvalid/m_tready    m_tdata data byte/frame total/error total,
//                                     m_tuser kind, m_tlast last beat of stream
//  cfg_     in   cfg_wr_en            cfg_wr_index register, cfg_wr_data value
//
//  one stream byte is taken per cycle; all eight bit steps of the crc divider
//  run in that cycle, so a byte's record is ready at the edge that accepts it
//  each byte leaves 0 to 3 output beats (data, flush, summary), emitted one
//  beat per cycle from the output register; the output port sets the rate
//  when bytes produce beats faster than one per cycle
//  the input stalls only when the four-entry record queue is full
//  aresetn is synchronous, active low; registers return to their reset values
//
// ----------------------------------------------------------------------------
`default_nettype none

module crc_codeword_stream_checker #(
    parameter int MAX_GEN_BITS = ccsc_pkg::MAX_GEN_BITS_DEF,
    parameter int COUNT_BITS   = ccsc_pkg::COUNT_BITS_DEF,
    localparam int CFG_W = (MAX_GEN_BITS > ccsc_pkg::GEN_LENGTH_W) ?
                           MAX_GEN_BITS : ccsc_pkg::GEN_LENGTH_W
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // stream bytes in
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // in_byte
    input  wire logic                              s_tlast,   // end_of_stream

    // results out
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // data_byte [7:0], frame_total [39:8], error_total [71:40]
    output logic [2*ccsc_pkg::TOTAL_W+7:0]         m_tdata,
    output logic                                   m_tuser,   // kind
    output logic                                   m_tlast,   // last

    // register writes: 0 gen_poly, 1 gen_length, 2 data_mode
    input  wire logic                              cfg_wr_en,
    input  wire logic [ccsc_pkg::CFG_INDEX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_W-1:0]                  cfg_wr_data
);

    ccsc_pkg::rec_t push_rec;
    ccsc_pkg::rec_t head_rec;
    logic           rec_push;
    logic           q_ready;
    logic           q_empty;
    logic           q_pop;
    logic           in_accept;

    // a byte is taken whenever the queue can hold its record
    assign s_tready  = q_ready;
    assign in_accept = s_tvalid && q_ready;

    // front: pad skip, crc division and data packing
    ccsc_front #(
        .MAX_GEN_BITS (MAX_GEN_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_accept    (in_accept),
        .in_byte      (s_tdata),
        .in_last      (s_tlast),
        .rec          (push_rec),
        .rec_push     (rec_push)
    );

    // records wait here so either side can stall on its own
    ccsc_queue #(
        .DEPTH   (ccsc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (rec_push),
        .wr_rec  (push_rec),
        .ready   (q_ready),
        .pop     (q_pop),
        .rd_rec  (head_rec),
        .empty   (q_empty)
    );

    // back: one beat per cycle into the output register while m_tready is high
    ccsc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head_rec),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
